>>> rtl/cle_pkg.sv
// cle_pkg: shared types and constants of the console line editor
// no dependencies; imported by cle_edit and console_line_editor
package cle_pkg;

  // configuration register indexes
  localparam logic REG_LINE_CAPACITY = 1'b0;
  localparam logic REG_IDLE_LIMIT    = 1'b1;

  // reset values of the configuration registers
  localparam logic [8:0]  LINE_CAPACITY_RESET = 9'd64;
  localparam logic [15:0] IDLE_LIMIT_RESET    = 16'd2000;

  // terminal bytes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  // input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result kinds
  localparam logic [1:0] RK_STORE = 2'd0;
  localparam logic [1:0] RK_ECHO  = 2'd1;
  localparam logic [1:0] RK_READY = 2'd2;
  localparam logic [1:0] RK_ABORT = 2'd3;

  // pending result run codes
  localparam logic [1:0] RUN_STORE   = 2'd0;
  localparam logic [1:0] RUN_ERASE   = 2'd1;
  localparam logic [1:0] RUN_NEWLINE = 2'd2;
  localparam logic [1:0] RUN_ABORT   = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [7:0] position;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  line_length;
    logic        swallow_linefeed;
    logic [15:0] idle_count;
  } edit_state_t;

  // one run of result words caused by a single item
  typedef struct packed {
    logic [1:0] code;
    logic [7:0] data;
    logic [7:0] position;
  } run_t;

endpackage

>>> rtl/cle_edit.sv
// cle_edit: next line state and pending result run for one input item
// depends on cle_pkg
module cle_edit (
  input  cle_pkg::in_word_t    item,
  input  cle_pkg::edit_state_t cur,
  input  logic [7:0]           accept_limit,
  input  logic [15:0]          idle_limit,
  output cle_pkg::edit_state_t nxt,
  output logic                 run_valid,
  output cle_pkg::run_t        run
);
  import cle_pkg::*;

  logic [15:0] idle_inc;
  logic [7:0]  c;

  assign c        = item.rx_byte;
  assign idle_inc = (cur.idle_count == 16'hffff) ? 16'hffff : cur.idle_count + 16'd1;

  always_comb begin
    nxt          = cur;
    run_valid    = 1'b0;
    run.code     = RUN_STORE;
    run.data     = c;
    run.position = cur.line_length;
    if (item.kind == KIND_TICK) begin
      if (cur.line_length == 8'd0) begin
        nxt.idle_count = 16'd0;
      end else if (idle_inc >= idle_limit) begin
        run_valid    = 1'b1;
        run.code     = RUN_ABORT;
        nxt          = '0;
      end else begin
        nxt.idle_count = idle_inc;
      end
    end else begin
      nxt.idle_count       = 16'd0;
      nxt.swallow_linefeed = 1'b0;
      if (cur.swallow_linefeed && c == CH_LF) begin
        // lf right after cr is dropped
      end else if (c == CH_BS || c == CH_DEL) begin
        if (cur.line_length != 8'd0) begin
          run_valid       = 1'b1;
          run.code        = RUN_ERASE;
          nxt.line_length = cur.line_length - 8'd1;
        end
      end else if (c == CH_CR || c == CH_LF) begin
        run_valid            = 1'b1;
        run.code             = RUN_NEWLINE;
        nxt.swallow_linefeed = (c == CH_CR);
        nxt.line_length      = 8'd0;
      end else if (c >= CH_SPACE && cur.line_length < accept_limit) begin
        run_valid       = 1'b1;
        run.code        = RUN_STORE;
        nxt.line_length = cur.line_length + 8'd1;
      end
    end
  end

endmodule

>>> rtl/console_line_editor.sv
// console_line_editor: serial console line editor with echo, top level
// depends on cle_pkg and cle_edit
//
// Takes one word per cycle unless in_stall is high: a received terminal byte
// or an idle tick. Each word is first caught in an input register, then run
// through the editor logic, which updates the line state and leaves its results
// in a run register; the output side emits that run one word per cycle while
// out_stall is low. A printable byte gives one word if the line has room,
// backspace/DEL on a non-empty line and CR/LF give three (not an LF right
// after a CR), an idle abort gives one, everything else gives none. Input words
// are taken back to back as long as each causes at most one result and the
// receiver does not stall; a three-word run holds up the words behind it, so
// the sustained rate is set by the single output port. The input register lets
// the next word in while a run is still draining. Configuration writes are
// always ready and should only be issued while no word is in flight.
module console_line_editor #(
  parameter int MAX_LINE = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cle_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cle_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import cle_pkg::*;

  // hard limit on accepted characters from the buffer size and the 8-bit length
  localparam int MaxLimInt = (MAX_LINE - 1 > 255) ? 255 : MAX_LINE - 1;
  localparam logic [8:0] MaxLim = 9'(MaxLimInt);

  // configuration registers
  logic [8:0]  line_capacity;
  logic [15:0] idle_limit;

  // input register
  logic        item_valid;
  in_word_t    item;

  // line state
  edit_state_t state;
  edit_state_t state_next;

  // pending run and its word counter
  logic        run_valid;
  run_t        run;
  logic [1:0]  step;
  logic        run_load;
  run_t        run_new;

  logic [8:0]  cap_m1;
  logic [8:0]  limit9;
  logic [7:0]  accept_limit;
  logic        out_take;
  logic        out_last;
  logic        slot_free;
  logic        item_move;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_capacity <= LINE_CAPACITY_RESET;
      idle_limit    <= IDLE_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINE_CAPACITY: line_capacity <= cfg_data[8:0];
        REG_IDLE_LIMIT:    idle_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept limit is the smallest of capacity - 1, MAX_LINE - 1 and 255
  assign cap_m1       = (line_capacity == 9'd0) ? 9'd0 : line_capacity - 9'd1;
  assign limit9       = (cap_m1 > MaxLim) ? MaxLim : cap_m1;
  assign accept_limit = limit9[7:0];

  // output side: one word of the run per cycle while out_stall is low
  assign out_last = (run.code == RUN_STORE) || (run.code == RUN_ABORT) || (step == 2'd2);
  assign out_take = run_valid && !out_stall;
  // the run register can take a new run now
  assign slot_free = !run_valid || (out_take && out_last);
  // the held word goes through the editor this cycle
  assign item_move = item_valid && slot_free;
  assign in_stall  = item_valid && !slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= (in_valid && !in_stall) || (item_valid && !item_move);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  cle_edit u_edit (
    .item         (item),
    .cur          (state),
    .accept_limit (accept_limit),
    .idle_limit   (idle_limit),
    .nxt          (state_next),
    .run_valid    (run_load),
    .run          (run_new)
  );

  // line state advances when the held word is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (item_move) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      step      <= 2'd0;
    end else if (item_move) begin
      run_valid <= run_load;
      step      <= 2'd0;
    end else if (out_take) begin
      // last word of the run leaves the register empty
      if (out_last) begin
        run_valid <= 1'b0;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_move && run_load) begin
      run <= run_new;
    end
  end

  // result word for the current step of the run
  always_comb begin
    out_data.result_kind = RK_ECHO;
    out_data.out_byte    = 8'd0;
    out_data.position    = 8'd0;
    out_data.last_of_run = out_last;
    case (run.code)
      RUN_STORE: begin
        out_data.result_kind = RK_STORE;
        out_data.out_byte    = run.data;
        out_data.position    = run.position;
      end
      RUN_ERASE: begin
        // backspace, space, backspace
        out_data.out_byte = (step == 2'd1) ? CH_SPACE : CH_BS;
      end
      RUN_NEWLINE: begin
        case (step)
          2'd0:    out_data.out_byte = CH_CR;
          2'd1:    out_data.out_byte = CH_LF;
          default: begin
            out_data.result_kind = RK_READY;
            out_data.position    = run.position;
          end
        endcase
      end
      default: begin
        out_data.result_kind = RK_ABORT;
        out_data.position    = run.position;
      end
    endcase
  end

  assign out_valid = run_valid;

  // line never grows past the hard limit
  a_len_limit: assert property (@(posedge clk) disable iff (rst)
    {1'b0, state.line_length} <= MaxLim)
    else $error("line length beyond limit");

  // an empty line carries no idle count
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state.line_length == 8'd0) |-> (state.idle_count == 16'd0))
    else $error("idle count on empty line");

  // single-word runs never advance their counter, multi-word runs stop at three
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (step != 2'd3) &&
      ((run.code == RUN_ERASE) || (run.code == RUN_NEWLINE) || (step == 2'd0)))
    else $error("run word counter out of range");

  // a finished run with nothing behind it leaves the output empty
  a_run_done: assert property (@(posedge clk) disable iff (rst)
    (out_take && out_last && !item_valid) |=> !out_valid)
    else $error("run repeated after last word");

endmodule

>>> verif/tb.sv
// tb: self-checking testbench for console_line_editor
// depends on cle_pkg and the console_line_editor rtl; needs nothing else
// tracks the line state per accepted word and checks every echo word in order
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int LINE_MAX = 256;

  // line state tracker: works out the echo words each accepted word causes
  // and holds them until the block hands them out
  class echo_tracker;
    logic [8:0]  cap;
    logic [15:0] abort_after;
    logic [7:0]  len;
    logic        eat_lf;
    logic [15:0] ticks_idle;
    out_word_t   echo_q[$];
    int          failures;

    function new();
      cap         = LINE_CAPACITY_RESET;
      abort_after = IDLE_LIMIT_RESET;
      len         = '0;
      eat_lf      = 1'b0;
      ticks_idle  = '0;
      failures    = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == REG_LINE_CAPACITY) begin
        cap = val[8:0];
      end else begin
        abort_after = val;
      end
    endfunction

    // characters a line may hold under the current capacity
    function int fill_limit();
      int lim;
      lim = (cap == 0) ? 0 : int'(cap) - 1;
      if (lim > LINE_MAX - 1) lim = LINE_MAX - 1;
      if (lim > 255) lim = 255;
      return lim;
    endfunction

    function void emit(logic [1:0] rk, logic [7:0] b, logic [7:0] pos, logic last);
      out_word_t w;
      w.result_kind = rk;
      w.out_byte    = b;
      w.position    = pos;
      w.last_of_run = last;
      echo_q.push_back(w);
    endfunction

    function void take_word(in_word_t w);
      logic [7:0] c;
      c = w.rx_byte;
      if (w.kind == KIND_TICK) begin
        if (len == 0) begin
          ticks_idle = '0;
          return;
        end
        if (ticks_idle != 16'hffff) ticks_idle++;
        if (ticks_idle >= abort_after) begin
          emit(RK_ABORT, 8'h00, len, 1'b1);
          len        = '0;
          ticks_idle = '0;
          eat_lf     = 1'b0;
        end
        return;
      end
      ticks_idle = '0;
      // one LF right after a CR is dropped
      if (eat_lf) begin
        eat_lf = 1'b0;
        if (c == CH_LF) return;
      end
      if (c == CH_BS || c == CH_DEL) begin
        if (len == 0) return;
        emit(RK_ECHO, CH_BS, 8'h00, 1'b0);
        emit(RK_ECHO, CH_SPACE, 8'h00, 1'b0);
        emit(RK_ECHO, CH_BS, 8'h00, 1'b1);
        len--;
      end else if (c == CH_CR || c == CH_LF) begin
        eat_lf = (c == CH_CR);
        emit(RK_ECHO, CH_CR, 8'h00, 1'b0);
        emit(RK_ECHO, CH_LF, 8'h00, 1'b0);
        emit(RK_READY, 8'h00, len, 1'b1);
        len = '0;
      end else if (c < CH_SPACE || len >= fill_limit()) begin
        return;
      end else begin
        emit(RK_STORE, c, len, 1'b1);
        len++;
      end
    endfunction

    function void check_echo(out_word_t got);
      out_word_t want;
      if (echo_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected word: kind %0d byte %02h pos %0d last %0d",
                   got.result_kind, got.out_byte, got.position, got.last_of_run);
        return;
      end
      want = echo_q.pop_front();
      if (got.result_kind !== want.result_kind || got.out_byte !== want.out_byte ||
          got.position !== want.position || got.last_of_run !== want.last_of_run) begin
        failures++;
        if (failures <= 10) begin
          $display("word mismatch: want kind %0d byte %02h pos %0d last %0d",
                   want.result_kind, want.out_byte, want.position, want.last_of_run);
          $display("               got  kind %0d byte %02h pos %0d last %0d",
                   got.result_kind, got.out_byte, got.position, got.last_of_run);
        end
      end
    endfunction
  endclass

  // block ports; every input is known from time zero
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = REG_LINE_CAPACITY;
  logic [15:0] cfg_data = '0;

  echo_tracker tracker = new();

  // words waiting to be offered to the block
  in_word_t word_q[$];

  // idle odds per side in percent, and a requested receiver hold-off in cycles
  int tx_idle_pct = 15;
  int rx_idle_pct = 15;
  int hold_len    = 0;

  console_line_editor #(.MAX_LINE(LINE_MAX)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  // ---------------------------------------------------------------------------
  // word builders
  // ---------------------------------------------------------------------------

  function automatic void push_byte(logic [7:0] b);
    in_word_t w;
    w.kind    = KIND_BYTE;
    w.rx_byte = b;
    word_q.push_back(w);
  endfunction

  // a tick carries a random byte that the block must ignore
  function automatic void push_tick();
    in_word_t w;
    w.kind    = KIND_TICK;
    w.rx_byte = 8'($urandom_range(0, 255));
    word_q.push_back(w);
  endfunction

  // mostly typed lines with edits and line ends, tick bursts long enough to
  // cross the idle limit now and then, plus some control bytes and raw noise
  function automatic void add_traffic(int n_words, int tick_span);
    int made;
    int pick;
    int k;
    in_word_t w;
    made = 0;
    while (made < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        // run of printable or high bytes, DEL slips in now and then
        k = $urandom_range(1, 6);
        repeat (k) push_byte(8'($urandom_range(32, 255)));
        made += k;
      end else if (pick < 60) begin
        push_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
        made++;
      end else if (pick < 72) begin
        // line end: CR, CR LF or a bare LF
        k = $urandom_range(0, 2);
        if (k == 2) push_byte(CH_LF);
        else push_byte(CH_CR);
        if (k == 1) push_byte(CH_LF);
        made++;
      end else if (pick < 78) begin
        push_byte(8'($urandom_range(0, 31)));
        made++;
      end else if (pick < 92) begin
        k = $urandom_range(1, tick_span);
        repeat (k) push_tick();
        made += k;
      end else begin
        w.kind    = 1'($urandom_range(0, 1));
        w.rx_byte = 8'($urandom_range(0, 255));
        word_q.push_back(w);
        made++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer every queued word; valid only drops for a random gap, never on stall
  task automatic send_all();
    in_word_t w;
    while (word_q.size() != 0) begin
      w = word_q.pop_front();
      if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= w;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      // word taken at this edge
      tracker.take_word(w);
    end
    in_valid <= 1'b0;
  endtask

  // wait for every expected word, bounded, then let the pipeline settle so a
  // word that causes nothing has surely left the block
  task automatic wait_idle();
    int n;
    n = 0;
    while (tracker.echo_q.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
  endtask

  // one register write; valid stays up so a second write can follow directly
  task automatic put_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic configure(logic [15:0] cap_val, logic [15:0] lim_val);
    put_reg(REG_LINE_CAPACITY, cap_val);
    put_reg(REG_IDLE_LIMIT, lim_val);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall, plus a long hold-off counted here when requested
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        hold_cnt = hold_len;
        hold_len = 0;
      end
      if (hold_cnt != 0) begin
        out_stall <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // every word the block hands out is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_echo(out_data);
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int caps   [7] = '{2, 3, 0, 1, 16'hb410, 511, 40};
    int limits [7] = '{1, 0, 4, 2, 7, 12, 30};
    int words  [7] = '{40, 40, 35, 30, 50, 50, 55};
    int spans  [7] = '{3, 2, 6, 4, 9, 14, 32};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // opening checks under reset settings (capacity 64, so 63 chars; 2000 ticks)
    push_byte(8'h41);
    push_byte(CH_SPACE);       // lowest printable
    push_byte(8'h7e);          // highest plain printable
    push_byte(8'h80);          // high bytes are stored too
    push_byte(8'hff);
    push_byte(CH_BS);
    push_byte(CH_DEL);
    push_byte(CH_CR);
    push_byte(CH_LF);          // swallowed after CR
    push_byte(CH_LF);          // bare LF: empty line ready
    push_byte(8'h00);          // control bytes ignored
    push_byte(8'h1f);
    push_byte(8'h1b);
    push_byte(CH_BS);          // erase on empty line
    push_tick();               // tick on empty line
    push_byte(8'h61);
    push_byte(CH_CR);
    push_byte(8'h62);          // byte after CR that is not LF is kept
    push_byte(CH_DEL);
    push_byte(8'h63);
    // partial line idles well short of the reset limit
    repeat (5) push_tick();
    send_all();
    wait_idle();

    // random phases over a spread of settings, capacity zero and one included;
    // phase five writes junk in the unused capacity bits and runs with no idling,
    // phase seven holds the receiver off long enough to back up the input
    for (int p = 0; p < 7; p++) begin
      configure(16'(caps[p]), 16'(limits[p]));
      add_traffic(words[p], spans[p]);
      if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 6) hold_len = 150;
      send_all();
      wait_idle();
      tx_idle_pct = 15;
      rx_idle_pct = 15;
    end

    // widest settings: a short line, then idle ticks far below the top limit
    configure(16'd256, 16'hffff);
    repeat (6) push_byte(8'($urandom_range(32, 126)));
    push_byte(CH_CR);
    push_byte(8'h7a);
    repeat (4) push_tick();
    send_all();
    wait_idle();

    if (tracker.echo_q.size() != 0) begin
      tracker.failures++;
      $display("%0d expected words never came out", tracker.echo_q.size());
    end
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin : watchdog
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
rtl/cle_pkg.sv
rtl/cle_edit.sv
rtl/console_line_editor.sv
verif/tb.sv
